FILE: rtl/terminal_key_escape_decoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the terminal key escape decoder
// Clocked concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_KEY_ESCAPE_DECODER_MACROS_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TKED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TKED_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TKED_ASSERT(lbl, prop, msg)
`define TKED_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/tked_pkg.sv
// ---------------------------------------------------------------------------
// Terminal key escape decoder package
// Parse phases, key codes, byte constants and the decode step record.
// ---------------------------------------------------------------------------
`default_nettype none

package tked_pkg;

	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_CSI   = 8'h5B;
	localparam logic [7:0] BYTE_SS3   = 8'h4F;
	localparam logic [7:0] BYTE_TILDE = 8'h7E;
	localparam logic [7:0] BYTE_A     = 8'h41;
	localparam logic [7:0] BYTE_B     = 8'h42;
	localparam logic [7:0] BYTE_C     = 8'h43;
	localparam logic [7:0] BYTE_D     = 8'h44;
	localparam logic [7:0] BYTE_F     = 8'h46;
	localparam logic [7:0] BYTE_H     = 8'h48;
	localparam logic [7:0] BYTE_ONE   = 8'h31;
	localparam logic [7:0] BYTE_SIX   = 8'h36;

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_ALT   = 2'd1;
	localparam logic [1:0] KIND_NAV   = 2'd2;

	localparam logic [7:0] NAV_UP        = 8'd0;
	localparam logic [7:0] NAV_DOWN      = 8'd1;
	localparam logic [7:0] NAV_LEFT      = 8'd2;
	localparam logic [7:0] NAV_RIGHT     = 8'd3;
	localparam logic [7:0] NAV_HOME      = 8'd4;
	localparam logic [7:0] NAV_END       = 8'd5;
	localparam logic [7:0] NAV_INSERT    = 8'd6;
	localparam logic [7:0] NAV_DELETE    = 8'd7;
	localparam logic [7:0] NAV_PAGE_UP   = 8'd8;
	localparam logic [7:0] NAV_PAGE_DOWN = 8'd9;
	localparam logic [7:0] NAV_LAST      = NAV_PAGE_DOWN;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_ESC   = 5'b00010,
		PH_CSI   = 5'b00100,
		PH_DIGIT = 5'b01000,
		PH_SS3   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} key_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] digit;
		logic       emit;
		key_t       key;
	} step_t;

	function automatic logic [7:0] digit_key(input logic [2:0] d);
		logic [7:0] k;
		case (d)
			3'd1:    k = NAV_HOME;
			3'd2:    k = NAV_INSERT;
			3'd3:    k = NAV_DELETE;
			3'd4:    k = NAV_END;
			3'd5:    k = NAV_PAGE_UP;
			3'd6:    k = NAV_PAGE_DOWN;
			default: k = NAV_UP;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/terminal_key_escape_decoder.sv
// ---------------------------------------------------------------------------
// Terminal key escape decoder
// Decodes plain bytes, alt bytes and VT100/ANSI navigation keys.
// ---------------------------------------------------------------------------
// One received byte is taken per clock cycle while in_ready is high; its key,
// if the byte completes one, goes to the result register, or to the skid
// register if an unread key waits there. One decode step lies between the
// parse phase register and the result register. A two-entry result buffer
// (result plus skid register) lets a byte in while one finished key waits;
// in_ready drops only when both entries hold keys. Bytes inside a sequence
// (ESC, '[', 'O', a digit) give no result. After reset the parser is idle.
`default_nettype none
`include "terminal_key_escape_decoder_macros.svh"

module terminal_key_escape_decoder import tked_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] key_kind,
	output logic [7:0] key_value
);

	phase_t     phase_q;
	logic [2:0] digit_q;
	step_t      step;
	logic       in_xfer;
	logic       out_xfer;
	logic       out_valid_q;
	logic       skid_valid_q;
	key_t       out_q;
	key_t       skid_q;

	tked_step u_step (
		.phase   (phase_q),
		.digit   (digit_q),
		.rx_byte (rx_byte),
		.step    (step)
	);

	assign in_ready = !skid_valid_q;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			digit_q <= 3'd0;
		end else if (in_xfer) begin
			phase_q <= step.phase;
			digit_q <= step.digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_xfer) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_xfer && step.emit) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_xfer) begin
				out_q <= skid_q;
			end
		end else if (in_xfer && step.emit) begin
			if (out_valid_q && !out_ready) begin
				skid_q <= step.key;
			end else begin
				out_q <= step.key;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign key_kind  = out_q.kind;
	assign key_value = out_q.value;

	`TKED_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid holds a key ahead of out")
	`TKED_ASSERT(a_plain_emits, in_xfer && phase_q == PH_IDLE && rx_byte != BYTE_ESC |=> out_valid_q, "plain byte gave no key")
	`TKED_ASSERT(a_csi_enter, in_xfer && phase_q == PH_ESC && rx_byte == BYTE_CSI |=> phase_q == PH_CSI && !$rose(out_valid_q), "ESC [ not tracked")
	`TKED_ASSERT(a_digit_held, phase_q != PH_DIGIT |-> digit_q == 3'd0, "digit held outside digit phase")
	`TKED_ASSERT(a_nav_range, out_valid_q && key_kind == KIND_NAV |-> key_value <= NAV_LAST, "navigation key id out of range")

endmodule

`default_nettype wire

FILE: rtl/tked_step.sv
// ---------------------------------------------------------------------------
// Terminal key escape decoder step
// Next parse phase, held digit and result key for one received byte.
// ---------------------------------------------------------------------------
`default_nettype none

module tked_step import tked_pkg::*; (
	input  phase_t     phase,
	input  logic [2:0] digit,
	input  logic [7:0] rx_byte,
	output step_t      step
);

	always_comb begin
		step.phase     = PH_IDLE;
		step.digit     = 3'd0;
		step.emit      = 1'b1;
		step.key.kind  = KIND_ALT;
		step.key.value = rx_byte;
		case (phase)
			PH_ESC: begin
				if (rx_byte == BYTE_CSI) begin
					step.phase = PH_CSI;
					step.emit  = 1'b0;
				end else if (rx_byte == BYTE_SS3) begin
					step.phase = PH_SS3;
					step.emit  = 1'b0;
				end
			end
			PH_CSI: begin
				if (rx_byte == BYTE_A) begin
					step.key = '{kind: KIND_NAV, value: NAV_UP};
				end else if (rx_byte == BYTE_B) begin
					step.key = '{kind: KIND_NAV, value: NAV_DOWN};
				end else if (rx_byte == BYTE_C) begin
					step.key = '{kind: KIND_NAV, value: NAV_RIGHT};
				end else if (rx_byte == BYTE_D) begin
					step.key = '{kind: KIND_NAV, value: NAV_LEFT};
				end else if (rx_byte >= BYTE_ONE && rx_byte <= BYTE_SIX) begin
					step.phase = PH_DIGIT;
					step.digit = rx_byte[2:0];
					step.emit  = 1'b0;
				end
			end
			PH_DIGIT: begin
				if (rx_byte == BYTE_TILDE) begin
					step.key = '{kind: KIND_NAV, value: digit_key(digit)};
				end
			end
			PH_SS3: begin
				if (rx_byte == BYTE_H) begin
					step.key = '{kind: KIND_NAV, value: NAV_HOME};
				end else if (rx_byte == BYTE_F) begin
					step.key = '{kind: KIND_NAV, value: NAV_END};
				end
			end
			default: begin
				if (rx_byte == BYTE_ESC) begin
					step.phase = PH_ESC;
					step.emit  = 1'b0;
				end else begin
					step.key.kind = KIND_PLAIN;
				end
			end
		endcase
	end

endmodule

`default_nettype wire
